FILE: hdl/ssod_pkg.sv
// ----------------------------------------------------------------------------
// ssod_pkg
// Shared types and constants for the send-on-delta sensor filter.
// ----------------------------------------------------------------------------
package ssod_pkg;

	localparam int SENSOR_COUNT = 10;
	localparam int IDX_W        = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	localparam int SLOT_W  = 4;
	localparam int DATA_W  = 16;
	localparam int DELTA_W = 8;
	localparam int CNT_W   = 4;

	localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
	localparam logic [DATA_W-1:0] THRESH_RESET  = DATA_W'(1);

	typedef enum logic {
		REQ_SAMPLE    = 1'b0,
		REQ_THRESHOLD = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [SLOT_W-1:0]  sensor_slot;
		logic [DATA_W-1:0]  data_value;
		logic               frame_last;
	} req_t;

	typedef struct packed {
		logic               reported;
		logic [SLOT_W-1:0]  report_sensor;
		logic [DELTA_W-1:0] delta_byte;
		logic [CNT_W-1:0]   report_position;
		logic               frame_end;
		logic [CNT_W-1:0]   frame_reports;
	} rsp_t;

	// stored state as seen for the slot under evaluation
	typedef struct packed {
		logic [DATA_W-1:0] last_value;
		logic [DATA_W-1:0] threshold;
		logic              primed;
		logic [CNT_W-1:0]  frame_count;
	} slot_rd_t;

	// state writes produced by one evaluated transaction
	typedef struct packed {
		logic              thr_we;
		logic              val_we;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] value;
		logic              cnt_we;
		logic [CNT_W-1:0]  cnt_next;
		logic              prime_set;
	} state_upd_t;

endpackage

FILE: hdl/ssod_ifs.sv
// ----------------------------------------------------------------------------
// ssod_ifs
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface ssod_req_if;
	import ssod_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ssod_rsp_if;
	import ssod_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ssod_state.sv
// ----------------------------------------------------------------------------
// ssod_state
// Per-sensor last-reported values and thresholds, prime flag, frame counter.
// ----------------------------------------------------------------------------
module ssod_state
	import ssod_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] rd_slot,
	input  state_upd_t        upd,
	output slot_rd_t          rd
);

	logic [DATA_W-1:0] last_values_q [SENSOR_COUNT];
	logic [DATA_W-1:0] thresholds_q  [SENSOR_COUNT];
	logic              primed_q;
	logic [CNT_W-1:0]  frame_count_q;

	logic             rd_in_range;
	logic [IDX_W-1:0] rd_idx;

	assign rd_in_range = (32'(rd_slot) < SENSOR_COUNT);
	assign rd_idx      = IDX_W'(rd_slot);

	always_comb begin
		rd.last_value  = rd_in_range ? last_values_q[rd_idx] : '0;
		rd.threshold   = rd_in_range ? thresholds_q[rd_idx]  : '0;
		rd.primed      = primed_q;
		rd.frame_count = frame_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				last_values_q[i] <= '0;
				thresholds_q[i]  <= THRESH_RESET;
			end
			primed_q      <= 1'b0;
			frame_count_q <= '0;
		end else begin
			if (upd.val_we) begin
				last_values_q[upd.idx] <= upd.value;
			end
			if (upd.thr_we) begin
				thresholds_q[upd.idx] <= upd.value;
			end
			if (upd.prime_set) begin
				primed_q <= 1'b1;
			end
			if (upd.cnt_we) begin
				frame_count_q <= upd.cnt_next;
			end
		end
	end

endmodule

FILE: hdl/ssod_eval.sv
// ----------------------------------------------------------------------------
// ssod_eval
// Deadband compare for one transaction: response fields and state writes.
// ----------------------------------------------------------------------------
module ssod_eval
	import ssod_pkg::*;
(
	input  logic       fire,
	input  req_t       item,
	input  slot_rd_t   rd,
	output rsp_t       rsp,
	output state_upd_t upd
);

	logic              in_range;
	logic              is_sample;
	logic [DATA_W-1:0] base_value;
	logic [DATA_W-1:0] delta;
	logic              hit;
	logic [CNT_W-1:0]  count_sat;
	logic [CNT_W-1:0]  total;

	assign in_range  = (32'(item.sensor_slot) < SENSOR_COUNT);
	assign is_sample = (item.req_type == REQ_SAMPLE);

	// before the first frame closes, the stored value is overwritten first
	assign base_value = rd.primed ? rd.last_value : item.data_value;
	assign delta      = (base_value >= item.data_value) ? (base_value - item.data_value)
	                                                    : (item.data_value - base_value);
	assign hit        = in_range && (delta >= rd.threshold);

	assign count_sat = (rd.frame_count == CNT_MAX) ? CNT_MAX : rd.frame_count + CNT_W'(1);
	assign total     = hit ? count_sat : rd.frame_count;

	always_comb begin
		rsp.reported        = hit;
		rsp.report_sensor   = item.sensor_slot;
		rsp.delta_byte      = in_range ? delta[DELTA_W-1:0] : '0;
		rsp.report_position = hit ? rd.frame_count : '0;
		rsp.frame_end       = item.frame_last;
		rsp.frame_reports   = total;

		upd.thr_we    = fire && !is_sample && in_range;
		upd.val_we    = fire && is_sample && in_range && (hit || !rd.primed);
		upd.idx       = IDX_W'(item.sensor_slot);
		upd.value     = item.data_value;
		upd.cnt_we    = fire && is_sample;
		upd.cnt_next  = item.frame_last ? '0 : total;
		upd.prime_set = fire && is_sample && item.frame_last;
	end

endmodule

FILE: hdl/sensor_send_on_delta_filter_core.sv
// ----------------------------------------------------------------------------
// sensor_send_on_delta_filter_core
// Send-on-delta change reporter with per-sensor thresholds.
// ----------------------------------------------------------------------------
//  channel  dir  payload  transaction
//  req      in   req_t    one sample or one threshold write
//  rsp      out  rsp_t    one result per sample, none per threshold write
//
//  A request passes through the input register, then the result register, to rsp.
//  Throughput is one transaction per cycle while rsp is not stalled, with state
//  read and written in the same cycle the registered request is evaluated.
//  Reset clears both valid flags, stored values to zero, thresholds to one.
//  A stalled rsp holds samples in the input register; threshold writes still pass.
// ----------------------------------------------------------------------------
module sensor_send_on_delta_filter_core
	import ssod_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ssod_req_if.sink   req,
	ssod_rsp_if.source rsp
);

	req_t       item_s1;
	logic       valid_s1;
	rsp_t       rsp_q;
	logic       rsp_valid_q;
	logic       is_thr;
	logic       advance;
	logic       emit;
	slot_rd_t   rd;
	rsp_t       rsp_next;
	state_upd_t upd;

	assign is_thr  = (item_s1.req_type == REQ_THRESHOLD);
	assign advance = valid_s1 && (is_thr || !rsp_valid_q || rsp.ready);
	assign emit    = advance && !is_thr;

	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	ssod_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_slot (item_s1.sensor_slot),
		.upd     (upd),
		.rd      (rd)
	);

	ssod_eval u_eval (
		.fire (advance),
		.item (item_s1),
		.rd   (rd),
		.rsp  (rsp_next),
		.upd  (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (emit) begin
			rsp_q <= rsp_next;
		end
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the send-on-delta filter core. A queue of pending
// requests feeds a clocked driver; a clocked monitor predicts every accepted
// request and checks each response against the oldest prediction. Source
// gaps and sink stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb;
	import ssod_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 125;

	logic clk;
	logic arst_n;

	ssod_req_if req_ch ();
	ssod_rsp_if rsp_ch ();

	sensor_send_on_delta_filter_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state
	logic [DATA_W-1:0] held_value [SENSOR_COUNT];
	logic [DATA_W-1:0] deadband   [SENSOR_COUNT];
	logic              is_primed;
	logic [CNT_W-1:0]  reports_in_frame;

	req_t stim_q [$];
	rsp_t expected_verdicts [$];

	// stimulus generator state
	int gen_level [SENSOR_COUNT];

	int  src_idle_pct;
	int  snk_stall_pct;
	logic req_taken;
	int  idle_cycles;
	int  errors;
	int  n_samples;
	int  n_reported;
	int  n_thr_writes;
	int  n_pushed;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void deadband_predict(input req_t r);
		rsp_t o;
		int slot;
		logic [DATA_W-1:0] prev;
		logic [DATA_W-1:0] dif;
		o = '0;
		slot = int'(r.sensor_slot);
		if (r.req_type == REQ_THRESHOLD) begin
			if (slot < SENSOR_COUNT)
				deadband[slot] = r.data_value;
			return;
		end
		if (slot < SENSOR_COUNT) begin
			if (!is_primed)
				held_value[slot] = r.data_value;
			prev = held_value[slot];
			dif  = (prev >= r.data_value) ? prev - r.data_value : r.data_value - prev;
			if (dif >= deadband[slot]) begin
				o.reported        = 1'b1;
				held_value[slot]  = r.data_value;
				o.report_position = reports_in_frame;
				if (reports_in_frame != CNT_MAX)
					reports_in_frame = reports_in_frame + 1'b1;
			end
			o.delta_byte = dif[DELTA_W-1:0];
		end
		o.report_sensor = r.sensor_slot;
		o.frame_end     = r.frame_last;
		o.frame_reports = reports_in_frame;
		if (r.frame_last) begin
			is_primed        = 1'b1;
			reports_in_frame = '0;
		end
		expected_verdicts.push_back(o);
	endfunction

	function automatic void check_field(input string fname, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, fname, exp_v, act_v);
		end
	endfunction

	// monitor: sample handshakes at the rising edge
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		req_taken = arst_n && req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.data.req_type == REQ_THRESHOLD)
					n_thr_writes++;
				else
					n_samples++;
				deadband_predict(req_ch.data);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (expected_verdicts.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected response, expected none, got %h", $time, got);
				end else begin
					want = expected_verdicts.pop_front();
					if (got.reported)
						n_reported++;
					check_field("reported", int'(want.reported), int'(got.reported));
					check_field("report_sensor", int'(want.report_sensor),
						int'(got.report_sensor));
					check_field("delta_byte", int'(want.delta_byte), int'(got.delta_byte));
					check_field("report_position", int'(want.report_position),
						int'(got.report_position));
					check_field("frame_end", int'(want.frame_end), int'(got.frame_end));
					check_field("frame_reports", int'(want.frame_reports),
						int'(got.frame_reports));
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: watchdog expired, %0d responses outstanding", $time,
					expected_verdicts.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	// driver: change inputs at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (stim_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				req_ch.data  <= stim_q.pop_front();
				req_ch.valid <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic push_item(input req_kind_t kind, input int slot, input int value,
		input bit last);
		req_t r;
		r.req_type    = kind;
		r.sensor_slot = SLOT_W'(slot);
		r.data_value  = DATA_W'(value);
		r.frame_last  = last;
		stim_q.push_back(r);
		n_pushed++;
	endtask

	function automatic int pick_threshold();
		int v;
		case ($urandom_range(7))
			0: v = 0;
			1: v = 65535;
			2: v = $urandom_range(65535);
			default: v = $urandom_range(64, 1);
		endcase
		return v;
	endfunction

	// one scan frame in sensor order with occasional threshold writes, values drifting around a running level
	task automatic push_scan_frame();
		int n;
		int spread;
		int v;
		n      = $urandom_range(SENSOR_COUNT, 1);
		spread = ($urandom_range(9) == 0) ? 40000 : $urandom_range(100, 1);
		for (int s = 0; s < n; s++) begin
			if ($urandom_range(9) == 0)
				push_item(REQ_THRESHOLD, s, pick_threshold(), 1'($urandom_range(1)));
			v = gen_level[s] + $urandom_range(2 * spread) - spread;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			gen_level[s] = v;
			push_item(REQ_SAMPLE, s, v, s == n - 1);
		end
	endtask

	// zero deadband and repeated samples of one sensor drive the count to saturation
	task automatic push_saturating_frame();
		int k;
		int n;
		k = $urandom_range(SENSOR_COUNT - 1);
		n = $urandom_range(20, 16);
		push_item(REQ_THRESHOLD, k, 0, 1'b0);
		for (int i = 0; i < n; i++)
			push_item(REQ_SAMPLE, k, $urandom_range(65535), i == n - 1);
	endtask

	task automatic push_noise();
		int n;
		n = $urandom_range(4, 1);
		for (int i = 0; i < n; i++)
			push_item(req_kind_t'($urandom_range(1)), $urandom_range(15), $urandom_range(65535),
				1'($urandom_range(1)));
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		rsp_ch.ready  = 1'b0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		idle_cycles   = 0;
		errors        = 0;
		n_samples     = 0;
		n_reported    = 0;
		n_thr_writes  = 0;
		n_pushed      = 0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			held_value[i] = '0;
			deadband[i]   = THRESH_RESET;
			gen_level[i]  = $urandom_range(65535);
		end
		is_primed        = 1'b0;
		reports_in_frame = '0;

		// directed: unprimed frame first, then extremes and corner cases
		push_item(REQ_THRESHOLD, 3, 0, 1'b1);        // frame mark on a write is ignored
		push_item(REQ_THRESHOLD, 12, 16'h1234, 1'b0); // out-of-range write dropped
		push_item(REQ_SAMPLE, 0, 16'hFFFF, 1'b0);
		push_item(REQ_SAMPLE, 3, 16'h8000, 1'b0);    // zero deadband reports while unprimed
		push_item(REQ_SAMPLE, 15, 16'hABCD, 1'b0);   // out-of-range sample
		push_item(REQ_SAMPLE, 9, 0, 1'b1);           // closes the priming frame
		push_item(REQ_SAMPLE, 0, 0, 1'b0);           // full-scale delta
		push_item(REQ_THRESHOLD, 1, 16'hFFFF, 1'b0);
		push_item(REQ_SAMPLE, 1, 16'hFFFF, 1'b0);
		push_item(REQ_SAMPLE, 1, 0, 1'b0);
		push_item(REQ_THRESHOLD, 2, 16'h0100, 1'b0);
		push_item(REQ_SAMPLE, 2, 16'h00FF, 1'b0);
		push_item(REQ_SAMPLE, 2, 16'h0100, 1'b0);    // delta truncates to zero byte
		push_item(REQ_SAMPLE, 3, 16'h8000, 1'b0);    // zero delta still reported
		push_item(REQ_SAMPLE, 10, 16'h5555, 1'b1);   // out-of-range sample ends frame
		push_item(REQ_SAMPLE, 9, 16'hFFFF, 1'b1);
		push_item(REQ_SAMPLE, 4, 16'h7FFF, 1'b0);
		push_item(REQ_THRESHOLD, 4, 16'h7FFF, 1'b0);
		push_item(REQ_SAMPLE, 4, 16'hFFFE, 1'b1);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
				default: begin src_idle_pct = 8; snk_stall_pct = 8; end
			endcase
			n_pushed = 0;
			while (n_pushed < PHASE_ITEMS) begin
				case ($urandom_range(9))
					0: push_saturating_frame();
					1, 2: push_noise();
					default: push_scan_frame();
				endcase
			end
			while (stim_q.size() != 0)
				@(negedge clk);
		end

		while (req_ch.valid)
			@(negedge clk);
		while (expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (expected_verdicts.size() != 0)
			errors++;

		$display("Covered %0d samples (%0d over deadband) and %0d threshold writes", n_samples,
			n_reported, n_thr_writes);
		$display("across free-running, source-gap, sink-stall and mixed pacing; %0d errors",
			errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
hdl/ssod_pkg.sv
hdl/ssod_ifs.sv
hdl/ssod_state.sv
hdl/ssod_eval.sv
hdl/sensor_send_on_delta_filter_core.sv
dv/tb.sv
